>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Sizes, status and operation codes, and the types shared by the queue cells
// and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  // queue geometry
  localparam int DEPTH      = 16;
  localparam int FLOOR_BITS = 6;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // valid priority range, smaller number served first
  localparam logic [2:0] PRIO_MIN = 3'd1;
  localparam logic [2:0] PRIO_MAX = 3'd6;

  // request kinds on the input channel
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADPRIO = 2'd3;

  // per-cell operation broadcast to the whole row
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_ENQ  = 2'd1;
  localparam logic [1:0] CELL_DEQ  = 2'd2;

  // one stored lift request
  typedef struct packed {
    logic [2:0]            prio;
    logic                  dir;
    logic [FLOOR_BITS-1:0] floor;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic [1:0] op;
    entry_t     ent;
  } cell_cmd_t;

endpackage

>>> sv/stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Stable priority queue unit
// Bounded sorted queue of lift requests built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The unit takes one request per clock and returns one result for each, in the
// cycle after acceptance. Every cell compares the new priority against its own
// entry and shifts in the same cycle, so neither enqueue nor dequeue depends
// on the fill level; the only stall comes from the result register when the
// consumer holds out_tready low. Enqueues land behind every stored entry of
// equal or smaller priority number, so equal priorities leave in arrival
// order. Dequeue returns the head entry; an empty dequeue, an enqueue to a
// full queue and an enqueue with priority 0 or 7 return their status codes
// and leave the queue untouched. No clearing pass is needed after reset.
module stable_priority_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // floor_in[5:0], dir_in[6], prio_in[9:7], zero[15:10]
  input  logic [0:0]  in_tuser,   // func[0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // floor_out[5:0], dir_out[6], prio_out[9:7],
                                  // fill_count[14:10], zero[15]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import spq_pkg::*;

  // request decode
  logic       in_fire;
  logic       func;
  logic [5:0] floor_in;
  logic       dir_in;
  logic [2:0] prio_in;
  logic       prio_bad;
  logic       full;
  logic       empty;
  logic       enq_ok;
  logic       deq_ok;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  cell_cmd_t cmd;
  entry_t    cell_ent  [DEPTH];
  logic      cell_keep [DEPTH];

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [1:0] out_status_r;
  logic [1:0] out_status_nxt;
  entry_t     out_ent_r;
  entry_t     out_ent_nxt;

  assign func     = in_tuser[0];
  assign floor_in = in_tdata[5:0];
  assign dir_in   = in_tdata[6];
  assign prio_in  = in_tdata[9:7];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign prio_bad = (prio_in < PRIO_MIN) || (prio_in > PRIO_MAX);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign enq_ok   = in_fire && (func == FUNC_ENQ) && !prio_bad && !full;
  assign deq_ok   = in_fire && (func == FUNC_DEQ) && !empty;

  // command broadcast to the row
  always_comb begin
    cmd.ent.prio  = prio_in;
    cmd.ent.dir   = dir_in;
    cmd.ent.floor = FLOOR_BITS'(floor_in);
    if (enq_ok) begin
      cmd.op = CELL_ENQ;
    end else if (deq_ok) begin
      cmd.op = CELL_DEQ;
    end else begin
      cmd.op = CELL_HOLD;
    end
  end

  // row of cells, head at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    logic   left_keep;
    entry_t right_ent;

    if (i == 0) begin : g_head
      assign left_ent  = cmd.ent;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = cell_ent[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (count_r > CNT_W'(i)),
      .left_ent  (left_ent),
      .left_keep (left_keep),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .keep      (cell_keep[i])
    );
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_ent_nxt   = '0;
      if (func == FUNC_ENQ) begin
        if (prio_bad) begin
          out_status_nxt = ST_BADPRIO;
        end else if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          out_status_nxt = ST_OK;
        end
      end else begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_status_nxt = ST_OK;
          out_ent_nxt    = cell_ent[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
  end

  // output packing; fill count reflects the state after the request
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, 5'(count_r), out_ent_r.prio, out_ent_r.dir,
                       6'(out_ent_r.floor)};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    enq_ok |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("accepted enqueue did not grow the queue");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (func == FUNC_DEQ) && empty |=> out_status_r == ST_EMPTY && count_r == '0)
    else $error("empty dequeue reported wrong status");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> cell_ent[0].prio <= cell_ent[1].prio)
    else $error("head entries out of priority order");

  a_result_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted request produced no result");

endmodule

>>> sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted row. On enqueue it keeps its entry, takes the new
// request or takes its left neighbor's entry; on dequeue it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic              occ,        // slot lies below the fill count
  input  spq_pkg::entry_t   left_ent,
  input  logic              left_keep,  // left slot stays put (tied high at head)
  input  spq_pkg::entry_t   right_ent,
  output spq_pkg::entry_t   ent,
  output logic              keep
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // stays put when it holds a request of equal or better priority
  assign keep = occ && (entry_r.prio <= cmd.ent.prio);
  assign ent  = entry_r;

  // slot update
  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.op)
      CELL_ENQ: begin
        if (keep) begin
          entry_nxt = entry_r;
        end else if (left_keep) begin
          entry_nxt = cmd.ent;
        end else begin
          entry_nxt = left_ent;
        end
      end
      CELL_DEQ: entry_nxt = right_ent;
      default:  entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> bench/stable_priority_queue_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue unit test
// Drives random and directed lift requests through the queue and checks
// every result against a behavioral copy of the sorted queue.
// ----------------------------------------------------------------------------
// A directed opening covers an empty dequeue, bad priorities, a fill to
// capacity with repeated priorities, an enqueue to a full queue, and
// dequeues that show first-in first-out order within one priority. Random
// bursts then lean toward filling, draining or mixing, across four phases
// of sender idling and receiver stalls.
module stable_priority_queue_unit_test;
  import spq_pkg::*;

  // one pending request with the idling phase it belongs to
  typedef struct {
    logic       func;
    logic [5:0] floor;
    logic       dir;
    logic [2:0] prio;
    int         phase;
  } lift_req_t;

  // one result as the unit should report it
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] floor;
    logic       dir;
    logic [2:0] prio;
    logic [4:0] fill;
  } lift_res_t;

  localparam int NUM_PHASES = 4;
  localparam int PHASE_ITEMS = 490;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = FUNC_ENQ;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  lift_req_t pending[$];
  lift_req_t next_req;
  int        bus_phase = 0;

  // behavioral copy of the queue, head at index 0
  entry_t    held_requests[$];
  lift_res_t due_results[$];
  lift_res_t want;

  int fail_count = 0;
  int served = 0;
  int peak_fill = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  stable_priority_queue_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // sender idle and receiver stall odds per phase, in percent
  function automatic int send_idle_pct(int phase);
    case (phase)
      1: return 61;
      3: return 29;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(int phase);
    case (phase)
      2: return 61;
      3: return 29;
      default: return 0;
    endcase
  endfunction

  // apply one request to the queue copy and return what the unit must answer
  function automatic lift_res_t serve_request(logic func, logic [5:0] floor,
                                              logic dir, logic [2:0] prio);
    lift_res_t res;
    entry_t    ent;
    int        slot;
    res = '0;
    if (func == FUNC_ENQ) begin
      if (prio < PRIO_MIN || prio > PRIO_MAX) begin
        res.status = ST_BADPRIO;
      end else if (held_requests.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        ent.prio  = prio;
        ent.dir   = dir;
        ent.floor = floor[FLOOR_BITS-1:0];
        // land behind every entry of equal or smaller priority number
        slot = 0;
        while (slot < held_requests.size() && held_requests[slot].prio <= prio)
          slot++;
        held_requests.insert(slot, ent);
        res.status = ST_OK;
      end
    end else if (held_requests.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      ent = held_requests.pop_front();
      res.status = ST_OK;
      res.floor  = ent.floor;
      res.dir    = ent.dir;
      res.prio   = ent.prio;
    end
    res.fill = 5'(held_requests.size());
    return res;
  endfunction

  task automatic add_req(logic func, logic [5:0] floor, logic dir,
                         logic [2:0] prio, int phase);
    lift_req_t r;
    r.func  = func;
    r.floor = floor;
    r.dir   = dir;
    r.prio  = prio;
    r.phase = phase;
    pending.push_back(r);
  endtask

  // driver: present the next pending request, hold it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= FUNC_ENQ;
    end else if (!in_tvalid || in_tready) begin
      if (pending.size() > 0 &&
          $urandom_range(99) >= send_idle_pct(pending[0].phase)) begin
        next_req = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {6'b0, next_req.prio, next_req.dir, next_req.floor};
        in_tuser  <= next_req.func;
        bus_phase <= next_req.phase;
      end else begin
        // idle cycle: junk on the data lines
        in_tvalid <= 1'b0;
        in_tdata  <= 16'($urandom_range(1023));
        in_tuser  <= 1'($urandom_range(1));
      end
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(serve_request(in_tuser[0], in_tdata[5:0],
                                            in_tdata[6], in_tdata[9:7]));
      end
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", out_tuser);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          served++;
          status_tally[want.status]++;
          if (want.fill > peak_fill)
            peak_fill = want.fill;
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[5:0] !== want.floor) begin
            $error("floor_out: expected %0d, actual %0d", want.floor, out_tdata[5:0]);
            fail_count++;
          end
          if (out_tdata[6] !== want.dir) begin
            $error("dir_out: expected %0d, actual %0d", want.dir, out_tdata[6]);
            fail_count++;
          end
          if (out_tdata[9:7] !== want.prio) begin
            $error("prio_out: expected %0d, actual %0d", want.prio, out_tdata[9:7]);
            fail_count++;
          end
          if (out_tdata[14:10] !== want.fill) begin
            $error("fill_count: expected %0d, actual %0d", want.fill,
                   out_tdata[14:10]);
            fail_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct(bus_phase));
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    logic [2:0] fill_prio [16];
    int         burst_len;
    int         enq_pct;
    int         made;
    logic       func;
    logic [2:0] prio;

    fill_prio = '{3'd6, 3'd1, 3'd3, 3'd3, 3'd6, 3'd1, 3'd2, 3'd5,
                  3'd4, 3'd3, 3'd1, 3'd6, 3'd2, 3'd5, 3'd4, 3'd1};

    // empty dequeue, then both invalid priorities
    add_req(FUNC_DEQ, 6'd63, 1'b1, 3'd7, 0);
    add_req(FUNC_ENQ, 6'd63, 1'b1, 3'd0, 0);
    add_req(FUNC_ENQ, 6'd0, 1'b0, 3'd7, 0);
    // fill to capacity with repeated priorities and extreme floors
    for (int i = 0; i < DEPTH; i++) begin
      add_req(FUNC_ENQ, (i == 0) ? 6'd0 : (i == 1) ? 6'd63 : 6'($urandom_range(63)),
              1'(i % 2), fill_prio[i], 0);
    end
    // full queue drops a good request; a bad priority still reports as bad
    add_req(FUNC_ENQ, 6'd21, 1'b1, 3'd1, 0);
    add_req(FUNC_ENQ, 6'd42, 1'b0, 3'd0, 0);
    // head entries leave in arrival order within priority 1
    for (int i = 0; i < 4; i++)
      add_req(FUNC_DEQ, 6'($urandom_range(63)), 1'($urandom_range(1)),
              3'($urandom_range(7)), 0);

    // random bursts that lean toward filling, draining or a mix
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      made = 0;
      while (made < PHASE_ITEMS) begin
        burst_len = $urandom_range(40, 8);
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 15;
          default: enq_pct = 50;
        endcase
        for (int k = 0; k < burst_len; k++) begin
          func = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
          if ($urandom_range(99) < 8)
            prio = $urandom_range(1) ? 3'd7 : 3'd0;
          else
            prio = 3'($urandom_range(PRIO_MAX, PRIO_MIN));
          add_req(func, 6'($urandom_range(63)), 1'($urandom_range(1)), prio, ph);
        end
        made += burst_len;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid)
      @(posedge clk);
    while (due_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d requests over %0d idling phases: %0d ok, %0d empty dequeues,",
             served, NUM_PHASES, status_tally[ST_OK], status_tally[ST_EMPTY]);
    $display("%0d full enqueues, %0d bad priorities; queue fill peaked at %0d of %0d.",
             status_tally[ST_FULL], status_tally[ST_BADPRIO], peak_fill, DEPTH);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout: %0d results still outstanding", due_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> stable_priority_queue_unit.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue_unit.sv
bench/stable_priority_queue_unit_test.sv
